[design/ccr_pkg.sv]
// Shared constants and the elaboration-time sRGB linearization functions.
`timescale 1ns / 1ps

package ccr_pkg;

  // Linear channel values and luminances: unsigned Q1.16, 65536 is 1.0
  localparam int LIN_BITS = 17;
  localparam int LUM_BITS = 17;
  // Integer bits of the contrast ratio (ratio is at most 21.0)
  localparam int RATIO_INT_BITS = 5;

  // Rec.709 luminance weights in Q0.16, summing to 65536
  localparam int WEIGHT_BITS = 16;
  localparam logic [WEIGHT_BITS-1:0] W_RED   = 16'd13933;
  localparam logic [WEIGHT_BITS-1:0] W_GREEN = 16'd46871;
  localparam logic [WEIGHT_BITS-1:0] W_BLUE  = 16'd4732;

  // Weighted sum width and rounding constant for the >>16
  localparam int SUM_BITS = LIN_BITS + WEIGHT_BITS;
  localparam logic [SUM_BITS-1:0] LUM_ROUND = 33'd32768;

  // 0.05 in Q0.16, added to both luminances before the ratio
  localparam logic [LUM_BITS-1:0] FLARE = 17'd3277;

  localparam logic [63:0] ONE_Q62 = 64'd1 << 62;

  // (a * b) >> 62 for a, b <= 1.0 in Q2.62
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // num / den in Q2.62, truncated; num <= den
  function automatic logic [63:0] div_q62(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] rem;
    logic [63:0] f;
    logic        q;
    q   = (num >= den);
    rem = q ? (num - den) : num;
    f   = 64'd0;
    for (int i = 0; i < 62; i++) begin
      f   = f << 1;
      rem = rem << 1;
      if (rem >= den) begin
        rem  = rem - den;
        f[0] = 1'b1;
      end
    end
    return {1'b0, q, f[61:0]};
  endfunction

  // Integer quotient by shift-and-subtract
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] r;
    logic [63:0] q;
    r = 65'd0;
    q = 64'd0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], num[i]};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] pow5_q62(input logic [63:0] r);
    logic [63:0] r2;
    logic [63:0] r4;
    r2 = mul_q62(r, r);
    r4 = mul_q62(r2, r2);
    return mul_q62(r4, r);
  endfunction

  // Largest r in [0, 1] with r^5 <= s, by bisection
  function automatic logic [63:0] root5_q62(input logic [63:0] s);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    lo = 64'd0;
    hi = ONE_Q62;
    for (int i = 0; i < 64; i++) begin
      if (lo < hi) begin
        mid = lo + ((hi - lo + 64'd1) >> 1);
        if (pow5_q62(mid) <= s) lo = mid;
        else hi = mid - 64'd1;
      end
    end
    return lo;
  endfunction

  // sRGB code k with full scale m to linear light, Q1.16 rounded
  function automatic logic [LIN_BITS-1:0] linearize(input logic [63:0] k,
                                                     input logic [63:0] m);
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] x;
    logic [63:0] q;
    if (64'd100000 * k <= 64'd4045 * m) begin
      q = udiv64(64'd13107200 * k + 64'd1292 * m, 64'd2584 * m);
      return q[LIN_BITS-1:0];
    end
    t = div_q62(64'd1000 * k + 64'd55 * m, 64'd1055 * m);
    s = mul_q62(t, t);
    x = mul_q62(s, root5_q62(s));
    q = (x + (64'd1 << 45)) >> 46;
    return q[LIN_BITS-1:0];
  endfunction

endpackage

[design/ccr_if.sv]
// Input and output channel interfaces of the contrast ratio block.
`timescale 1ns / 1ps

interface ccr_in_if #(
  parameter int CHANNEL_BITS = 8
);
  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] a_red;
  logic [CHANNEL_BITS-1:0] a_green;
  logic [CHANNEL_BITS-1:0] a_blue;
  logic [CHANNEL_BITS-1:0] b_red;
  logic [CHANNEL_BITS-1:0] b_green;
  logic [CHANNEL_BITS-1:0] b_blue;

  modport source (output valid, a_red, a_green, a_blue, b_red, b_green, b_blue,
                  input ready);
  modport sink (input valid, a_red, a_green, a_blue, b_red, b_green, b_blue,
                output ready);
endinterface

interface ccr_out_if #(
  parameter int RATIO_FRACTION_BITS = 11
);
  logic                                                  valid;
  logic                                                  ready;
  logic [ccr_pkg::LUM_BITS-1:0]                          lum_a;
  logic [ccr_pkg::LUM_BITS-1:0]                          lum_b;
  logic                                                  a_is_lighter;
  logic [RATIO_FRACTION_BITS+ccr_pkg::RATIO_INT_BITS-1:0] ratio;

  modport source (output valid, lum_a, lum_b, a_is_lighter, ratio, input ready);
  modport sink (input valid, lum_a, lum_b, a_is_lighter, ratio, output ready);
endinterface

[design/ccr_lum_lane.sv]
// One luminance lane: table lookup, weighting and rounded sum for one color.
`timescale 1ns / 1ps

module ccr_lum_lane #(
  parameter int CHANNEL_BITS = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_vld,
  output logic                         in_rdy,
  input  logic [CHANNEL_BITS-1:0]      red,
  input  logic [CHANNEL_BITS-1:0]      green,
  input  logic [CHANNEL_BITS-1:0]      blue,
  output logic                         out_vld,
  input  logic                         out_rdy,
  output logic [ccr_pkg::LUM_BITS-1:0] lum
);

  localparam int LutSize = 1 << CHANNEL_BITS;
  localparam int LinW    = ccr_pkg::LIN_BITS;
  localparam int SumW    = ccr_pkg::SUM_BITS;

  typedef logic [LinW-1:0] lut_t [LutSize];

  function automatic lut_t build_lut();
    lut_t tab;
    for (int k = 0; k < LutSize; k++) begin
      tab[k] = ccr_pkg::linearize(64'(k), 64'(LutSize - 1));
    end
    return tab;
  endfunction

  localparam lut_t LinLut = build_lut();

  logic            vld1, vld2, vld3;
  logic            en1, en2, en3;
  logic [LinW-1:0] lin_red, lin_green, lin_blue;
  logic [SumW-1:0] prod_red, prod_green, prod_blue;
  logic [SumW-1:0] sum;
  logic [ccr_pkg::LUM_BITS-1:0] lum_q;

  // stall chain: a stage loads when empty or when its contents move on
  assign en3    = !vld3 || out_rdy;
  assign en2    = !vld2 || en3;
  assign en1    = !vld1 || en2;
  assign in_rdy = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld3 <= 1'b0;
    end else begin
      if (en1) vld1 <= in_vld;
      if (en2) vld2 <= vld1;
      if (en3) vld3 <= vld2;
    end
  end

  // stage 1: registered table reads
  always_ff @(posedge clk) begin
    if (en1) begin
      lin_red   <= LinLut[red];
      lin_green <= LinLut[green];
      lin_blue  <= LinLut[blue];
    end
  end

  // stage 2: weights
  always_ff @(posedge clk) begin
    if (en2) begin
      prod_red   <= {{LinW{1'b0}}, ccr_pkg::W_RED} *
                    {{ccr_pkg::WEIGHT_BITS{1'b0}}, lin_red};
      prod_green <= {{LinW{1'b0}}, ccr_pkg::W_GREEN} *
                    {{ccr_pkg::WEIGHT_BITS{1'b0}}, lin_green};
      prod_blue  <= {{LinW{1'b0}}, ccr_pkg::W_BLUE} *
                    {{ccr_pkg::WEIGHT_BITS{1'b0}}, lin_blue};
    end
  end

  // stage 3: sum, round half up, drop 16 fraction bits
  assign sum = prod_red + prod_green + prod_blue + ccr_pkg::LUM_ROUND;

  always_ff @(posedge clk) begin
    if (en3) lum_q <= sum[SumW-1:16];
  end

  assign out_vld = vld3;
  assign lum     = lum_q;

endmodule

[design/ccr_merge.sv]
// Merge stage: orders the two luminances and divides out the contrast ratio.
`timescale 1ns / 1ps

module ccr_merge #(
  parameter int RATIO_FRACTION_BITS = 11
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_vld,
  output logic                         in_rdy,
  input  logic [ccr_pkg::LUM_BITS-1:0] lum_a_in,
  input  logic [ccr_pkg::LUM_BITS-1:0] lum_b_in,
  output logic                         res_vld,
  input  logic                         res_rdy,
  output logic [ccr_pkg::LUM_BITS-1:0] lum_a,
  output logic [ccr_pkg::LUM_BITS-1:0] lum_b,
  output logic                         a_is_lighter,
  output logic [RATIO_FRACTION_BITS+ccr_pkg::RATIO_INT_BITS-1:0] ratio
);

  localparam int IntW = ccr_pkg::RATIO_INT_BITS;
  localparam int QW   = RATIO_FRACTION_BITS + IntW;
  localparam int LW   = ccr_pkg::LUM_BITS;

  typedef struct packed {
    logic [LW-1:0] lum_a;
    logic [LW-1:0] lum_b;
    logic          a_lighter;
    logic [LW-1:0] den;
    logic [LW-1:0] rem;
    logic [QW-1:0] bits;
    logic [QW-1:0] quo;
  } div_stage_t;

  div_stage_t    stage_q [QW+1];
  logic          vld [QW+1];
  logic          en [QW+1];

  logic          a_ge;
  logic [LW-1:0] hi_lum, lo_lum, num_hi;
  div_stage_t    first;

  // stall chain through every stage
  assign en[QW] = !vld[QW] || res_rdy;
  for (genvar j = 0; j < QW; j++) begin : g_en
    assign en[j] = !vld[j] || en[j+1];
  end
  assign in_rdy = en[0];

  // compare and offset; first remainder is numerator >> QW, always below den
  assign a_ge   = (lum_a_in >= lum_b_in);
  assign hi_lum = a_ge ? lum_a_in : lum_b_in;
  assign lo_lum = a_ge ? lum_b_in : lum_a_in;
  assign num_hi = hi_lum + ccr_pkg::FLARE;

  always_comb begin
    first.lum_a     = lum_a_in;
    first.lum_b     = lum_b_in;
    first.a_lighter = a_ge;
    first.den       = lo_lum + ccr_pkg::FLARE;
    first.rem       = num_hi >> IntW;
    first.bits      = {num_hi[IntW-1:0], {RATIO_FRACTION_BITS{1'b0}}};
    first.quo       = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else if (en[0]) vld[0] <= in_vld;
  end

  always_ff @(posedge clk) begin
    if (en[0]) stage_q[0] <= first;
  end

  // one quotient bit per stage
  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [LW:0]  trial;
    logic [LW:0]  diff;
    logic         ge;
    div_stage_t   step;

    assign trial = {stage_q[j].rem, stage_q[j].bits[QW-1]};
    assign diff  = trial - {1'b0, stage_q[j].den};
    assign ge    = (trial >= {1'b0, stage_q[j].den});

    always_comb begin
      step      = stage_q[j];
      step.rem  = ge ? diff[LW-1:0] : trial[LW-1:0];
      step.bits = stage_q[j].bits << 1;
      step.quo  = {stage_q[j].quo[QW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (rst) vld[j+1] <= 1'b0;
      else if (en[j+1]) vld[j+1] <= vld[j];
    end

    always_ff @(posedge clk) begin
      if (en[j+1]) stage_q[j+1] <= step;
    end
  end

  assign res_vld      = vld[QW];
  assign lum_a        = stage_q[QW].lum_a;
  assign lum_b        = stage_q[QW].lum_b;
  assign a_is_lighter = stage_q[QW].a_lighter;
  assign ratio        = stage_q[QW].quo;

endmodule

[design/color_contrast_ratio_top.sv]
// Top level of the WCAG contrast ratio block: two luminance lanes and the merge.
// Takes one pair of sRGB colors per transfer and returns, per pair, both relative
// luminances (unsigned Q1.16, 65536 = 1.0), a flag that is set when the first
// color is at least as light as the second, and the contrast ratio
// (hi + 0.05) / (lo + 0.05) truncated to unsigned Q5.RATIO_FRACTION_BITS.
// Throughput is one pair per clock while the output is not stalled. The stages
// are three lane stages (registered table read, weighting multiply, rounded sum),
// one compare stage, and a pipelined restoring divider that retires one quotient
// bit per stage over RATIO_FRACTION_BITS + 5 stages. Every stage has its own valid
// bit and loads when empty or when its contents move on, so gaps fill up and new
// pairs are taken while a result waits at the output. The linearization tables
// are constant ROMs of 2^CHANNEL_BITS entries, one per lane for all channels,
// built at elaboration from the sRGB transfer curve.
`timescale 1ns / 1ps

module color_contrast_ratio_top #(
  parameter int CHANNEL_BITS        = 8,
  parameter int RATIO_FRACTION_BITS = 11
) (
  input logic      clk,
  input logic      rst,
  ccr_in_if.sink   pair,
  ccr_out_if.source res
);

  logic                         rdy_a, rdy_b;
  logic                         vld_a, vld_b;
  logic                         merge_rdy;
  logic [ccr_pkg::LUM_BITS-1:0] lum_a, lum_b;

  // both lanes run in lockstep; combining their handshakes keeps them paired
  assign pair.ready = rdy_a & rdy_b;

  ccr_lum_lane #(
    .CHANNEL_BITS(CHANNEL_BITS)
  ) u_lane_a (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (pair.valid & rdy_b),
    .in_rdy  (rdy_a),
    .red     (pair.a_red),
    .green   (pair.a_green),
    .blue    (pair.a_blue),
    .out_vld (vld_a),
    .out_rdy (merge_rdy & vld_b),
    .lum     (lum_a)
  );

  ccr_lum_lane #(
    .CHANNEL_BITS(CHANNEL_BITS)
  ) u_lane_b (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (pair.valid & rdy_a),
    .in_rdy  (rdy_b),
    .red     (pair.b_red),
    .green   (pair.b_green),
    .blue    (pair.b_blue),
    .out_vld (vld_b),
    .out_rdy (merge_rdy & vld_a),
    .lum     (lum_b)
  );

  // ordering, flare offset and division
  ccr_merge #(
    .RATIO_FRACTION_BITS(RATIO_FRACTION_BITS)
  ) u_merge (
    .clk          (clk),
    .rst          (rst),
    .in_vld       (vld_a & vld_b),
    .in_rdy       (merge_rdy),
    .lum_a_in     (lum_a),
    .lum_b_in     (lum_b),
    .res_vld      (res.valid),
    .res_rdy      (res.ready),
    .lum_a        (res.lum_a),
    .lum_b        (res.lum_b),
    .a_is_lighter (res.a_is_lighter),
    .ratio        (res.ratio)
  );

endmodule

[dv/tb.sv]
// Self-checking testbench for color_contrast_ratio_top: table-driven and random color pairs.
`timescale 1ns / 1ps

module tb;

  localparam int LIN_BITS   = ccr_pkg::LIN_BITS;
  localparam int LUM_BITS   = ccr_pkg::LUM_BITS;
  localparam int CH_BITS    = 8;
  localparam int FRAC_BITS  = 11;
  localparam int RATIO_BITS = FRAC_BITS + ccr_pkg::RATIO_INT_BITS;
  localparam int CH_CODES   = 1 << CH_BITS;

  // Independent copies of the luminance weights and the 0.05 flare term
  localparam longint unsigned WR    = 13933;
  localparam longint unsigned WG    = 46871;
  localparam longint unsigned WB    = 4732;
  localparam longint unsigned FLARE_Q16 = 3277;
  localparam logic [63:0] Q62_ONE = 64'd1 << 62;

  localparam int NUM_ROWS     = 18;
  localparam int RANDOM_PAIRS = 1832;
  // The tail of the random part runs with both sides streaming flat out
  localparam int CALM_TAIL    = 200;
  // Pipeline depth is FRAC_BITS + 9; drain with a margin of twice that
  localparam int DRAIN_CYCLES = 2 * (FRAC_BITS + 9);

  typedef struct packed {
    logic [CH_BITS-1:0] a_red;
    logic [CH_BITS-1:0] a_green;
    logic [CH_BITS-1:0] a_blue;
    logic [CH_BITS-1:0] b_red;
    logic [CH_BITS-1:0] b_green;
    logic [CH_BITS-1:0] b_blue;
  } color_pair_t;

  typedef struct packed {
    logic [LUM_BITS-1:0]   lum_a;
    logic [LUM_BITS-1:0]   lum_b;
    logic                  a_is_lighter;
    logic [RATIO_BITS-1:0] ratio;
  } contrast_t;

  // One directed row: a color pair and, where obvious, the result typed in
  typedef struct packed {
    color_pair_t colors;
    logic        typed;
    contrast_t   want;
  } directed_row_t;

  logic clk;
  logic rst;

  ccr_in_if  #(.CHANNEL_BITS(CH_BITS))         pair_bus ();
  ccr_out_if #(.RATIO_FRACTION_BITS(FRAC_BITS)) res_bus ();

  color_contrast_ratio_top #(
    .CHANNEL_BITS       (CH_BITS),
    .RATIO_FRACTION_BITS(FRAC_BITS)
  ) dut (
    .clk (clk),
    .rst (rst),
    .pair(pair_bus),
    .res (res_bus)
  );

  // sRGB code to linear light, Q1.16, built once before the first transfer
  logic [LIN_BITS-1:0] linear_light [CH_CODES];
  // Contrast results owed by the block, oldest first
  contrast_t           pending_contrasts [$];
  int unsigned         mismatches;
  // Set for the tail of the run: no gaps on the input, no stalls on the output
  bit                  calm;

  // Directed stimulus. Black/white combinations carry their known answers:
  // white is exactly 65536, black is 0, equal colors give ratio 1.0 (2048),
  // and white over black is 68813*2048/3277 = 43005 truncated.
  directed_row_t directed_rows [NUM_ROWS] = '{
    '{'{8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0},   1'b1,
      '{17'd0,     17'd0,     1'b1, 16'd2048}},
    '{'{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255}, 1'b1,
      '{17'd65536, 17'd65536, 1'b1, 16'd2048}},
    '{'{8'd255, 8'd255, 8'd255, 8'd0,   8'd0,   8'd0},   1'b1,
      '{17'd65536, 17'd0,     1'b1, 16'd43005}},
    '{'{8'd0,   8'd0,   8'd0,   8'd255, 8'd255, 8'd255}, 1'b1,
      '{17'd0,     17'd65536, 1'b0, 16'd43005}},
    // single primaries against black, both orders
    '{'{8'd255, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0},   1'b0, '0},
    '{'{8'd0,   8'd255, 8'd0,   8'd0,   8'd0,   8'd0},   1'b0, '0},
    '{'{8'd0,   8'd0,   8'd255, 8'd0,   8'd0,   8'd0},   1'b0, '0},
    '{'{8'd0,   8'd0,   8'd0,   8'd255, 8'd0,   8'd0},   1'b0, '0},
    '{'{8'd0,   8'd0,   8'd0,   8'd0,   8'd255, 8'd0},   1'b0, '0},
    '{'{8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd255}, 1'b0, '0},
    // last code on the linear segment against the first on the power curve, then near-rail codes
    '{'{8'd10,  8'd10,  8'd10,  8'd11,  8'd11,  8'd11},  1'b0, '0},
    '{'{8'd11,  8'd11,  8'd11,  8'd10,  8'd10,  8'd10},  1'b0, '0},
    '{'{8'd1,   8'd1,   8'd1,   8'd254, 8'd254, 8'd254}, 1'b0, '0},
    // same color on both sides: equal luminance
    '{'{8'd17,  8'd200, 8'd90,  8'd17,  8'd200, 8'd90},  1'b0, '0},
    // alternating bit patterns, then grays and mixed colors
    '{'{8'd85,  8'd170, 8'd85,  8'd170, 8'd85,  8'd170}, 1'b0, '0},
    '{'{8'd128, 8'd128, 8'd128, 8'd118, 8'd118, 8'd118}, 1'b0, '0},
    '{'{8'd255, 8'd255, 8'd0,   8'd0,   8'd0,   8'd255}, 1'b0, '0},
    '{'{8'd0,   8'd255, 8'd255, 8'd255, 8'd0,   8'd0},   1'b0, '0}
  };

  // 20 ns clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Prediction: fixed-point sRGB curve and the contrast ratio
  // ---------------------------------------------------------------------------

  // Truncated Q2.62 product
  function automatic logic [63:0] q62_mul(input logic [63:0] x, input logic [63:0] y);
    logic [127:0] full;
    full = 128'(x) * 128'(y);
    return 64'(full >> 62);
  endfunction

  // Truncated Q2.62 quotient, num <= den
  function automatic logic [63:0] q62_div(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] rem;
    logic [63:0] frac;
    logic        whole;
    whole = (num >= den);
    rem   = whole ? num - den : num;
    frac  = '0;
    for (int i = 0; i < 62; i++) begin
      rem  = rem * 2;
      frac = frac * 2;
      if (rem >= den) begin
        rem  = rem - den;
        frac = frac + 1;
      end
    end
    return (64'(whole) << 62) | frac;
  endfunction

  // Largest r in [0, 1] with r^5 <= s, by bisection over Q2.62
  function automatic logic [63:0] q62_fifth_root(input logic [63:0] s);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] sq;
    lo = '0;
    hi = Q62_ONE;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      sq  = q62_mul(mid, mid);
      if (q62_mul(q62_mul(sq, sq), mid) <= s) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  // WCAG transfer curve: linear below 0.04045, ((c+0.055)/1.055)^2.4 above.
  // The 2.4 power is t^2 times the fifth root of t^2.
  function automatic logic [LIN_BITS-1:0] srgb_to_linear(input int unsigned code);
    longint unsigned full_scale;
    longint unsigned k;
    logic [63:0]     t;
    logic [63:0]     t2;
    logic [63:0]     x;
    full_scale = CH_CODES - 1;
    k          = code;
    if (100000 * k <= 4045 * full_scale)
      return LIN_BITS'((13107200 * k + 1292 * full_scale) / (2584 * full_scale));
    t  = q62_div(1000 * k + 55 * full_scale, 1055 * full_scale);
    t2 = q62_mul(t, t);
    x  = q62_mul(t2, q62_fifth_root(t2));
    return LIN_BITS'((x + (64'd1 << 45)) >> 46);
  endfunction

  // Rounded Rec.709 weighted sum of three linearized channels
  function automatic logic [LUM_BITS-1:0] luminance_of(input logic [CH_BITS-1:0] r,
                                                       input logic [CH_BITS-1:0] g,
                                                       input logic [CH_BITS-1:0] b);
    longint unsigned acc;
    acc = WR * linear_light[r] + WG * linear_light[g] + WB * linear_light[b];
    return LUM_BITS'((acc + 32768) >> 16);
  endfunction

  function automatic contrast_t contrast_of(input color_pair_t p);
    contrast_t       c;
    longint unsigned lighter;
    longint unsigned darker;
    c.lum_a        = luminance_of(p.a_red, p.a_green, p.a_blue);
    c.lum_b        = luminance_of(p.b_red, p.b_green, p.b_blue);
    c.a_is_lighter = (c.lum_a >= c.lum_b);
    lighter        = c.a_is_lighter ? c.lum_a : c.lum_b;
    darker         = c.a_is_lighter ? c.lum_b : c.lum_a;
    c.ratio        = RATIO_BITS'(((lighter + FLARE_Q16) << FRAC_BITS) /
                                 (darker + FLARE_Q16));
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Hold one pair on the bus until its transfer. With no gap requested valid
  // stays high from the previous pair, so it is assigned once per edge.
  task automatic send_pair(input color_pair_t p, input logic typed, input contrast_t want);
    if (!calm && $urandom_range(0, 7) == 0) begin
      pair_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    pair_bus.valid   <= 1'b1;
    pair_bus.a_red   <= p.a_red;
    pair_bus.a_green <= p.a_green;
    pair_bus.a_blue  <= p.a_blue;
    pair_bus.b_red   <= p.b_red;
    pair_bus.b_green <= p.b_green;
    pair_bus.b_blue  <= p.b_blue;
    // Values read right after the edge are the ones the block sampled there
    do @(posedge clk); while (!pair_bus.ready);
    pending_contrasts.push_back(typed ? want : contrast_of(p));
  endtask

  function automatic logic [CH_BITS-1:0] edge_code();
    // Rails and the two codes around the linear/power knee
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      2:       return CH_BITS'(10);
      default: return CH_BITS'(11);
    endcase
  endfunction

  // Random pairs, mixed so that equal and near-equal luminances come up often
  function automatic color_pair_t random_pair();
    color_pair_t p;
    int unsigned g;
    p = color_pair_t'(48'({$urandom, $urandom}));
    case ($urandom_range(0, 9))
      6: begin
        p.b_red   = p.a_red;
        p.b_green = p.a_green;
        p.b_blue  = p.a_blue;
      end
      7: begin
        p.a_red = edge_code(); p.a_green = edge_code(); p.a_blue = edge_code();
        p.b_red = edge_code(); p.b_green = edge_code(); p.b_blue = edge_code();
      end
      8: begin
        // second color one code away from the first on one channel
        p.b_red   = p.a_red;
        p.b_green = p.a_green;
        p.b_blue  = p.a_blue;
        case ($urandom_range(0, 2))
          0:       p.b_red   = p.a_red + CH_BITS'($urandom_range(0, 1) ? 1 : -1);
          1:       p.b_green = p.a_green + CH_BITS'($urandom_range(0, 1) ? 1 : -1);
          default: p.b_blue  = p.a_blue + CH_BITS'($urandom_range(0, 1) ? 1 : -1);
        endcase
      end
      9: begin
        g = $urandom_range(0, CH_CODES - 1);
        p.a_red = CH_BITS'(g); p.a_green = CH_BITS'(g); p.a_blue = CH_BITS'(g);
        g = $urandom_range(0, CH_CODES - 1);
        p.b_red = CH_BITS'(g); p.b_green = CH_BITS'(g); p.b_blue = CH_BITS'(g);
      end
      default: ;
    endcase
    return p;
  endfunction

  initial begin
    rst              = 1'b1;
    calm             = 1'b0;
    mismatches       = 0;
    pair_bus.valid   <= 1'b0;
    pair_bus.a_red   <= '0;
    pair_bus.a_green <= '0;
    pair_bus.a_blue  <= '0;
    pair_bus.b_red   <= '0;
    pair_bus.b_green <= '0;
    pair_bus.b_blue  <= '0;
    for (int k = 0; k < CH_CODES; k++) linear_light[k] = srgb_to_linear(k);

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send_pair(directed_rows[i].colors, directed_rows[i].typed, directed_rows[i].want);

    for (int n = 0; n < RANDOM_PAIRS; n++) begin
      if (n == RANDOM_PAIRS - CALM_TAIL) calm = 1'b1;
      send_pair(random_pair(), 1'b0, '0);
    end
    pair_bus.valid <= 1'b0;

    // Drain: everything owed has arrived, then watch for strays a while longer
    while (pending_contrasts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("color_contrast_ratio_top regression: pass");
    end else begin
      $display("color_contrast_ratio_top regression: fail");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Output side: ready drops in random bursts until the calm tail
  // ---------------------------------------------------------------------------

  initial begin
    res_bus.ready <= 1'b0;
    @(negedge rst);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        res_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        res_bus.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: each result transfer against the oldest owed contrast
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("%0d ns: %s", $time, what);
  endtask

  always @(posedge clk) begin
    contrast_t want;
    if (!rst && res_bus.valid && res_bus.ready) begin
      if (pending_contrasts.size() == 0) begin
        report_mismatch($sformatf("unexpected result lum_a=%0d lum_b=%0d lighter=%0b ratio=%0d",
                                  res_bus.lum_a, res_bus.lum_b, res_bus.a_is_lighter,
                                  res_bus.ratio));
      end else begin
        want = pending_contrasts.pop_front();
        if (res_bus.lum_a !== want.lum_a || res_bus.lum_b !== want.lum_b ||
            res_bus.a_is_lighter !== want.a_is_lighter || res_bus.ratio !== want.ratio) begin
          report_mismatch($sformatf(
            "expected lum_a=%0d lum_b=%0d lighter=%0b ratio=%0d, got %0d %0d %0b %0d",
            want.lum_a, want.lum_b, want.a_is_lighter, want.ratio,
            res_bus.lum_a, res_bus.lum_b, res_bus.a_is_lighter, res_bus.ratio));
        end
      end
    end
  end

  // Watchdog: fires far beyond the slowest legal run
  initial begin
    #10000000;
    $display("color_contrast_ratio_top regression: fail");
    $finish;
  end

endmodule
